// ===== design/cpd_pkg.sv =====
// Package for the camera point projection block: Q.24 types, saturating arithmetic,
// coefficient slot codes and the context record that travels down the pipeline.
// No dependencies.
package cpd_pkg;

  typedef logic signed [63:0] q_t;

  localparam int FRAC      = 24;
  localparam int NUM_COEFS = 21;
  localparam int IDX_W     = 5;
  localparam int DIV_STEPS = 64;

  localparam q_t Q_MAX = {1'b0, {63{1'b1}}};
  localparam q_t Q_MIN = {1'b1, {63{1'b0}}};
  localparam q_t Q_ONE = q_t'(64'd1 << FRAC);

  typedef enum logic {
    ACT_PROJECT = 1'b0,
    ACT_LOAD    = 1'b1
  } action_t;

  localparam logic [IDX_W-1:0] C_CX = 5'd12;
  localparam logic [IDX_W-1:0] C_CY = 5'd13;
  localparam logic [IDX_W-1:0] C_FX = 5'd14;
  localparam logic [IDX_W-1:0] C_FY = 5'd15;
  localparam logic [IDX_W-1:0] C_K1 = 5'd16;
  localparam logic [IDX_W-1:0] C_K2 = 5'd17;
  localparam logic [IDX_W-1:0] C_K3 = 5'd18;
  localparam logic [IDX_W-1:0] C_P1 = 5'd19;
  localparam logic [IDX_W-1:0] C_P2 = 5'd20;

  typedef struct packed {
    logic     bad;
    logic     hneg_u;
    logic     hneg_v;
    logic     fxz;
    logic     fyz;
    q_t [2:0] hoff;
    q_t [2:0] ps;
    q_t [2:0] mm;
    q_t [2:0] h;
    q_t       cx, cy, fx, fy, k1, k2, k3, p1, p2;
    q_t       du, dv;
    q_t       dx, dy, dx2, dy2, dxdy, r2, rad;
    q_t       p1d, p2d, tdx, tdy, tx, ty;
    q_t       xs, ys, ex, ey, xx, yy, pu, pv;
  } ctx_t;

  function automatic q_t sadd(q_t a, q_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return q_t'(s[63:0]);
  endfunction

  function automatic q_t ssub(q_t a, q_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return q_t'(s[63:0]);
  endfunction

  // magnitude with overflow flag back to signed, saturating
  function automatic q_t sat_mag(logic neg, logic hi, logic [63:0] m);
    if (neg) begin
      if (hi || (m[63] && (|m[62:0]))) return Q_MIN;
      return q_t'(64'd0 - m);
    end
    if (hi || m[63]) return Q_MAX;
    return q_t'(m);
  endfunction

  function automatic logic [63:0] mag(q_t a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

endpackage

// ===== design/cpd_mul.sv =====
// Pipelined Q.24 multiplier lanes: magnitude, 32x32 partial products, round and saturate.
// Three register stages; a context record and valid bit travel alongside.
// Depends on cpd_pkg.
module cpd_mul #(
  parameter int N = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  cpd_pkg::ctx_t ctx_i,
  input  cpd_pkg::q_t   a [N],
  input  cpd_pkg::q_t   b [N],
  output logic          vld_o,
  output cpd_pkg::ctx_t ctx_o,
  output cpd_pkg::q_t   p [N]
);

  logic [2:0]    vs;
  cpd_pkg::ctx_t c1, c2;
  logic          neg1 [N];
  logic          neg2 [N];
  logic [63:0]   ua [N];
  logic [63:0]   ub [N];
  logic [63:0]   pp [N][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    logic [127:0] full;
    logic [103:0] m;
    if (en) begin
      c1    <= ctx_i;
      c2    <= c1;
      ctx_o <= c2;
      for (int n = 0; n < N; n++) begin
        neg1[n] <= a[n][63] ^ b[n][63];
        ua[n]   <= cpd_pkg::mag(a[n]);
        ub[n]   <= cpd_pkg::mag(b[n]);
        neg2[n] <= neg1[n];
        pp[n][0] <= ua[n][31:0]  * ub[n][31:0];
        pp[n][1] <= ua[n][31:0]  * ub[n][63:32];
        pp[n][2] <= ua[n][63:32] * ub[n][31:0];
        pp[n][3] <= ua[n][63:32] * ub[n][63:32];
        full = {64'd0, pp[n][0]} + ({64'd0, pp[n][1]} << 32) + ({64'd0, pp[n][2]} << 32)
             + {pp[n][3], 64'd0} + (128'd1 << (cpd_pkg::FRAC - 1));
        m = full[127:cpd_pkg::FRAC];
        p[n] <= cpd_pkg::sat_mag(neg2[n], |m[103:64], m[63:0]);
      end
    end
  end

  assign vld_o = vs[2];

endmodule

// ===== design/cpd_div.sv =====
// Pipelined Q.24 divider lanes: restoring division, one quotient bit per stage,
// round to nearest and saturate. Depends on cpd_pkg.
module cpd_div #(
  parameter int N = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  cpd_pkg::ctx_t ctx_i,
  input  cpd_pkg::q_t   n_i [N],
  input  cpd_pkg::q_t   d_i [N],
  output logic          vld_o,
  output cpd_pkg::ctx_t ctx_o,
  output cpd_pkg::q_t   q_o [N]
);

  localparam int S = cpd_pkg::DIV_STEPS;

  logic [S+1:0]  vs;
  cpd_pkg::ctx_t cs [S+1];
  logic [63:0]   rr [S+1][N];
  logic [63:0]   qq [S+1][N];
  logic [63:0]   nl [S+1][N];
  logic [63:0]   ud [S+1][N];
  logic          ng [S+1][N];
  logic          ov [S+1][N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[S:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] un;
    logic [63:0] dd;
    logic [64:0] t;
    logic [64:0] qr;
    if (en) begin
      cs[0] <= ctx_i;
      for (int n = 0; n < N; n++) begin
        un = cpd_pkg::mag(n_i[n]);
        dd = cpd_pkg::mag(d_i[n]);
        ng[0][n] <= n_i[n][63] ^ d_i[n][63];
        ud[0][n] <= dd;
        // integer part of the quotient nonzero means saturation
        ov[0][n] <= {40'd0, un[63:40]} >= dd;
        rr[0][n] <= {40'd0, un[63:40]};
        nl[0][n] <= {un[39:0], 24'd0};
        qq[0][n] <= '0;
      end
      for (int k = 0; k < S; k++) begin
        cs[k+1] <= cs[k];
        for (int n = 0; n < N; n++) begin
          t = {rr[k][n], nl[k][n][63]};
          ng[k+1][n] <= ng[k][n];
          ov[k+1][n] <= ov[k][n];
          ud[k+1][n] <= ud[k][n];
          nl[k+1][n] <= {nl[k][n][62:0], 1'b0};
          if (t >= {1'b0, ud[k][n]}) begin
            rr[k+1][n] <= 64'(t - {1'b0, ud[k][n]});
            qq[k+1][n] <= {qq[k][n][62:0], 1'b1};
          end else begin
            rr[k+1][n] <= t[63:0];
            qq[k+1][n] <= {qq[k][n][62:0], 1'b0};
          end
        end
      end
      ctx_o <= cs[S];
      for (int n = 0; n < N; n++) begin
        qr = {1'b0, qq[S][n]} + 65'(rr[S][n] >= (ud[S][n] - rr[S][n]));
        q_o[n] <= cpd_pkg::sat_mag(ng[S][n], ov[S][n] | qr[64], qr[63:0]);
      end
    end
  end

  assign vld_o = vs[S+1];

endmodule

// ===== design/camera_point_projection_distortion.sv =====
// Top level of the pinhole projection with radial and tangential lens distortion.
// Depends on cpd_pkg, cpd_mul and cpd_div.
//
// Input channel s_*: s_tuser is the action (0 project a point, 1 load a coefficient).
// A load item writes coef_value into slot coef_index (slots above 20 are ignored)
// and gives no result. A project item uses the table as it stands when the item is
// accepted and gives one result on m_*: pixel_u and pixel_v in m_tdata, the zero
// depth flag in m_tuser.
// The datapath is one pipeline of 166 register stages: 2 two-lane dividers of 66 stages
// (one quotient bit per stage, u/v then dx/dy), multipliers of 3 stages and single
// stages of saturating adds. An item can be accepted every cycle while the pipeline
// is not held. Items leave in order.
// Reset is synchronous and clears the coefficient table and all valid bits.
// When the receiver holds m_tready low with a result waiting, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated.
module camera_point_projection_distortion #(
  parameter int COEF_WIDTH  = 48,
  parameter int POINT_WIDTH = 32,
  localparam int S_TDATA_W = ((cpd_pkg::IDX_W + COEF_WIDTH + 3 * POINT_WIDTH + 7) / 8) * 8,
  localparam int M_TDATA_W = ((2 * POINT_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // coef_index, coef_value, point_x, point_y, point_z
  input  logic [S_TDATA_W-1:0] s_tdata,
  // action
  input  logic [0:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // pixel_u, pixel_v
  output logic [M_TDATA_W-1:0] m_tdata,
  // depth_bad
  output logic [0:0]           m_tuser
);

  localparam int PW = POINT_WIDTH;
  localparam logic [PW-1:0] PIX_MAX = {1'b0, {(PW - 1){1'b1}}};
  localparam logic [PW-1:0] PIX_MIN = {1'b1, {(PW - 1){1'b0}}};

  logic                         en;
  logic [cpd_pkg::IDX_W-1:0]    coef_index;
  logic signed [COEF_WIDTH-1:0] coef_value;
  logic signed [PW-1:0]         point_x, point_y, point_z;
  logic                         load_go;

  logic signed [COEF_WIDTH-1:0] coef_tab [cpd_pkg::NUM_COEFS];
  cpd_pkg::q_t                  cq [cpd_pkg::NUM_COEFS];

  assign coef_index = s_tdata[cpd_pkg::IDX_W-1:0];
  assign coef_value = s_tdata[cpd_pkg::IDX_W +: COEF_WIDTH];
  assign point_x    = s_tdata[cpd_pkg::IDX_W + COEF_WIDTH +: PW];
  assign point_y    = s_tdata[cpd_pkg::IDX_W + COEF_WIDTH + PW +: PW];
  assign point_z    = s_tdata[cpd_pkg::IDX_W + COEF_WIDTH + 2 * PW +: PW];

  logic out_vld;
  assign en       = !out_vld || m_tready;
  assign s_tready = en;
  assign load_go  = s_tvalid && s_tready && (s_tuser[0] == cpd_pkg::ACT_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cpd_pkg::NUM_COEFS; i++) coef_tab[i] <= '0;
    end else if (load_go && (coef_index < cpd_pkg::IDX_W'(cpd_pkg::NUM_COEFS))) begin
      coef_tab[coef_index] <= coef_value;
    end
  end

  always_comb begin
    for (int i = 0; i < cpd_pkg::NUM_COEFS; i++) cq[i] = cpd_pkg::q_t'(coef_tab[i]);
  end

  // ---------------- stage 0: snapshot of the table and point ----------------
  logic          v0;
  cpd_pkg::ctx_t c0, c0_next;
  cpd_pkg::q_t   pm0 [12];
  cpd_pkg::q_t   pt0 [3];

  always_comb begin
    c0_next = '0;
    for (int i = 0; i < 3; i++) c0_next.hoff[i] = cq[4 * i + 3];
    c0_next.cx = cq[cpd_pkg::C_CX];
    c0_next.cy = cq[cpd_pkg::C_CY];
    c0_next.fx = cq[cpd_pkg::C_FX];
    c0_next.fy = cq[cpd_pkg::C_FY];
    c0_next.k1 = cq[cpd_pkg::C_K1];
    c0_next.k2 = cq[cpd_pkg::C_K2];
    c0_next.k3 = cq[cpd_pkg::C_K3];
    c0_next.p1 = cq[cpd_pkg::C_P1];
    c0_next.p2 = cq[cpd_pkg::C_P2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0 <= c0_next;
      for (int i = 0; i < 12; i++) pm0[i] <= cq[i];
      pt0[0] <= cpd_pkg::q_t'(point_x) << 8;
      pt0[1] <= cpd_pkg::q_t'(point_y) << 8;
      pt0[2] <= cpd_pkg::q_t'(point_z) << 8;
    end
  end

  // ---------------- h = P * (X,Y,Z,1) ----------------
  cpd_pkg::q_t   ma [9], mb [9], pa [9];
  logic          va;
  cpd_pkg::ctx_t ca;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ma[3 * i + j] = pm0[4 * i + j];
        mb[3 * i + j] = pt0[j];
      end
    end
  end

  cpd_mul #(.N(9)) u_mul_h (
    .clk, .rst, .en, .vld_i(v0), .ctx_i(c0), .a(ma), .b(mb),
    .vld_o(va), .ctx_o(ca), .p(pa)
  );

  logic          vb1, vb2;
  cpd_pkg::ctx_t cb1, cb1_next, cb2, cb2_next;

  always_comb begin
    cb1_next = ca;
    for (int i = 0; i < 3; i++) begin
      cb1_next.ps[i] = cpd_pkg::sadd(pa[3 * i], pa[3 * i + 1]);
      cb1_next.mm[i] = pa[3 * i + 2];
    end
  end

  always_comb begin
    cb2_next = cb1;
    for (int i = 0; i < 3; i++) begin
      cb2_next.h[i] = cpd_pkg::sadd(cpd_pkg::sadd(cb1.ps[i], cb1.mm[i]), cb1.hoff[i]);
    end
    cb2_next.bad    = (cb2_next.h[2] == '0);
    cb2_next.hneg_u = cb2_next.h[0][63];
    cb2_next.hneg_v = cb2_next.h[1][63];
  end

  // ---------------- u = h0/h2, v = h1/h2 ----------------
  cpd_pkg::q_t   dn1 [2], dd1 [2], dq1 [2];
  logic          vd1;
  cpd_pkg::ctx_t cd1;

  always_comb begin
    dn1[0] = cb2.h[0];
    dn1[1] = cb2.h[1];
    dd1[0] = cb2.h[2];
    dd1[1] = cb2.h[2];
  end

  cpd_div #(.N(2)) u_div_uv (
    .clk, .rst, .en, .vld_i(vb2), .ctx_i(cb2), .n_i(dn1), .d_i(dd1),
    .vld_o(vd1), .ctx_o(cd1), .q_o(dq1)
  );

  logic          v3;
  cpd_pkg::ctx_t c3, c3_next;

  always_comb begin
    c3_next     = cd1;
    c3_next.du  = cpd_pkg::ssub(dq1[0], cd1.cx);
    c3_next.dv  = cpd_pkg::ssub(dq1[1], cd1.cy);
    c3_next.fxz = (cd1.fx == '0);
    c3_next.fyz = (cd1.fy == '0);
  end

  // ---------------- dx = (u-cx)/fx, dy = (v-cy)/fy ----------------
  cpd_pkg::q_t   dn2 [2], dd2 [2], dq2 [2];
  logic          vd2;
  cpd_pkg::ctx_t cd2;

  always_comb begin
    dn2[0] = c3.du;
    dn2[1] = c3.dv;
    dd2[0] = c3.fx;
    dd2[1] = c3.fy;
  end

  cpd_div #(.N(2)) u_div_d (
    .clk, .rst, .en, .vld_i(v3), .ctx_i(c3), .n_i(dn2), .d_i(dd2),
    .vld_o(vd2), .ctx_o(cd2), .q_o(dq2)
  );

  logic          v4;
  cpd_pkg::ctx_t c4, c4_next;

  always_comb begin
    c4_next    = cd2;
    c4_next.dx = cd2.fxz ? '0 : dq2[0];
    c4_next.dy = cd2.fyz ? '0 : dq2[1];
  end

  // ---------------- squares and cross term ----------------
  cpd_pkg::q_t   m2a [3], m2b [3], m2p [3];
  logic          vm2;
  cpd_pkg::ctx_t cm2;

  always_comb begin
    m2a[0] = c4.dx; m2b[0] = c4.dx;
    m2a[1] = c4.dy; m2b[1] = c4.dy;
    m2a[2] = c4.dx; m2b[2] = c4.dy;
  end

  cpd_mul #(.N(3)) u_mul_sq (
    .clk, .rst, .en, .vld_i(v4), .ctx_i(c4), .a(m2a), .b(m2b),
    .vld_o(vm2), .ctx_o(cm2), .p(m2p)
  );

  logic          v5;
  cpd_pkg::ctx_t c5, c5_next;

  always_comb begin
    c5_next      = cm2;
    c5_next.dx2  = m2p[0];
    c5_next.dy2  = m2p[1];
    c5_next.dxdy = m2p[2];
    c5_next.r2   = cpd_pkg::sadd(m2p[0], m2p[1]);
    c5_next.tdx  = cpd_pkg::sadd(m2p[0], m2p[0]);
    c5_next.tdy  = cpd_pkg::sadd(m2p[1], m2p[1]);
    c5_next.p1d  = cpd_pkg::sadd(cm2.p1, cm2.p1);
    c5_next.p2d  = cpd_pkg::sadd(cm2.p2, cm2.p2);
  end

  // ---------------- radial polynomial, Horner form ----------------
  cpd_pkg::q_t   m3a [1], m3b [1], m3p [1];
  logic          vm3;
  cpd_pkg::ctx_t cm3;

  assign m3a[0] = c5.r2;
  assign m3b[0] = c5.k3;

  cpd_mul #(.N(1)) u_mul_r3 (
    .clk, .rst, .en, .vld_i(v5), .ctx_i(c5), .a(m3a), .b(m3b),
    .vld_o(vm3), .ctx_o(cm3), .p(m3p)
  );

  logic          v6;
  cpd_pkg::ctx_t c6, c6_next;

  always_comb begin
    c6_next     = cm3;
    c6_next.rad = cpd_pkg::sadd(cm3.k2, m3p[0]);
    c6_next.tx  = cpd_pkg::sadd(cm3.r2, cm3.tdx);
    c6_next.ty  = cpd_pkg::sadd(cm3.r2, cm3.tdy);
  end

  cpd_pkg::q_t   m4a [1], m4b [1], m4p [1];
  logic          vm4;
  cpd_pkg::ctx_t cm4;

  assign m4a[0] = c6.r2;
  assign m4b[0] = c6.rad;

  cpd_mul #(.N(1)) u_mul_r2 (
    .clk, .rst, .en, .vld_i(v6), .ctx_i(c6), .a(m4a), .b(m4b),
    .vld_o(vm4), .ctx_o(cm4), .p(m4p)
  );

  logic          v7;
  cpd_pkg::ctx_t c7, c7_next;

  always_comb begin
    c7_next     = cm4;
    c7_next.rad = cpd_pkg::sadd(cm4.k1, m4p[0]);
  end

  cpd_pkg::q_t   m5a [1], m5b [1], m5p [1];
  logic          vm5;
  cpd_pkg::ctx_t cm5;

  assign m5a[0] = c7.r2;
  assign m5b[0] = c7.rad;

  cpd_mul #(.N(1)) u_mul_r1 (
    .clk, .rst, .en, .vld_i(v7), .ctx_i(c7), .a(m5a), .b(m5b),
    .vld_o(vm5), .ctx_o(cm5), .p(m5p)
  );

  logic          v8;
  cpd_pkg::ctx_t c8, c8_next;

  always_comb begin
    c8_next     = cm5;
    c8_next.rad = cpd_pkg::sadd(cpd_pkg::Q_ONE, m5p[0]);
  end

  // ---------------- distortion terms ----------------
  cpd_pkg::q_t   m6a [6], m6b [6], m6p [6];
  logic          vm6;
  cpd_pkg::ctx_t cm6;

  always_comb begin
    m6a[0] = c8.dx;  m6b[0] = c8.rad;
    m6a[1] = c8.p1d; m6b[1] = c8.dxdy;
    m6a[2] = c8.p2;  m6b[2] = c8.tx;
    m6a[3] = c8.dy;  m6b[3] = c8.rad;
    m6a[4] = c8.p2d; m6b[4] = c8.dxdy;
    m6a[5] = c8.p1;  m6b[5] = c8.ty;
  end

  cpd_mul #(.N(6)) u_mul_dist (
    .clk, .rst, .en, .vld_i(v8), .ctx_i(c8), .a(m6a), .b(m6b),
    .vld_o(vm6), .ctx_o(cm6), .p(m6p)
  );

  logic          v9, v10;
  cpd_pkg::ctx_t c9, c9_next, c10, c10_next;

  always_comb begin
    c9_next    = cm6;
    c9_next.xs = cpd_pkg::sadd(m6p[0], m6p[1]);
    c9_next.ex = m6p[2];
    c9_next.ys = cpd_pkg::sadd(m6p[3], m6p[4]);
    c9_next.ey = m6p[5];
  end

  always_comb begin
    c10_next    = c9;
    c10_next.xx = cpd_pkg::sadd(c9.xs, c9.ex);
    c10_next.yy = cpd_pkg::sadd(c9.ys, c9.ey);
  end

  // ---------------- back to pixels ----------------
  cpd_pkg::q_t   m7a [2], m7b [2], m7p [2];
  logic          vm7;
  cpd_pkg::ctx_t cm7;

  always_comb begin
    m7a[0] = c10.fx; m7b[0] = c10.xx;
    m7a[1] = c10.fy; m7b[1] = c10.yy;
  end

  cpd_mul #(.N(2)) u_mul_px (
    .clk, .rst, .en, .vld_i(v10), .ctx_i(c10), .a(m7a), .b(m7b),
    .vld_o(vm7), .ctx_o(cm7), .p(m7p)
  );

  logic          v11;
  cpd_pkg::ctx_t c11, c11_next;

  always_comb begin
    c11_next    = cm7;
    c11_next.pu = cpd_pkg::sadd(cm7.cx, m7p[0]);
    c11_next.pv = cpd_pkg::sadd(cm7.cy, m7p[1]);
  end

  // Q.24 to Q.16, ties away from zero, saturated to PW bits
  function automatic logic [PW-1:0] to_pixel(cpd_pkg::q_t q);
    logic [63:0] am;
    logic [56:0] m;
    am = cpd_pkg::mag(q);
    m  = 57'((65'(am) + 65'd128) >> 8);
    if (q[63]) begin
      if (m > 57'(PIX_MIN)) return PIX_MIN;
      return PW'(57'd0 - m);
    end
    if (m > 57'(PIX_MAX)) return PIX_MAX;
    return PW'(m);
  endfunction

  logic [PW-1:0] out_u, out_v;
  logic          out_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; vb1 <= 1'b0; vb2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v0  <= s_tvalid && (s_tuser[0] == cpd_pkg::ACT_PROJECT);
      vb1 <= va;
      vb2 <= vb1;
      v3  <= vd1;
      v4  <= vd2;
      v5  <= vm2;
      v6  <= vm3;
      v7  <= vm4;
      v8  <= vm5;
      v9  <= vm6;
      v10 <= v9;
      v11 <= vm7;
      out_vld <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cb1 <= cb1_next;
      cb2 <= cb2_next;
      c3  <= c3_next;
      c4  <= c4_next;
      c5  <= c5_next;
      c6  <= c6_next;
      c7  <= c7_next;
      c8  <= c8_next;
      c9  <= c9_next;
      c10 <= c10_next;
      c11 <= c11_next;
      if (v11) begin
        out_bad <= c11.bad;
        if (c11.bad) begin
          out_u <= c11.hneg_u ? PIX_MIN : PIX_MAX;
          out_v <= c11.hneg_v ? PIX_MIN : PIX_MAX;
        end else begin
          out_u <= to_pixel(c11.pu);
          out_v <= to_pixel(c11.pv);
        end
      end
    end
  end

  assign m_tvalid   = out_vld;
  assign m_tdata    = M_TDATA_W'({out_v, out_u});
  assign m_tuser[0] = out_bad;

endmodule

// ===== design/cpd_chk.sv =====
// Port-level checker for camera_point_projection_distortion, attached by bind.
// Depends on the top level's ports only.
module cpd_chk #(
  parameter int POINT_WIDTH = 32,
  localparam int M_TDATA_W = ((2 * POINT_WIDTH + 7) / 8) * 8
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [0:0]           m_tuser
);

  localparam int PW = POINT_WIDTH;
  localparam logic [PW-1:0] PIX_MAX = {1'b0, {(PW - 1){1'b1}}};
  localparam logic [PW-1:0] PIX_MIN = {1'b1, {(PW - 1){1'b0}}};

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  a_bad_saturates: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (m_tdata[PW-1:0] == PIX_MAX || m_tdata[PW-1:0] == PIX_MIN) &&
      (m_tdata[2*PW-1:PW] == PIX_MAX || m_tdata[2*PW-1:PW] == PIX_MIN))
    else $error("zero depth result not saturated");

endmodule

bind camera_point_projection_distortion cpd_chk #(
  .POINT_WIDTH(POINT_WIDTH)
) u_cpd_chk (.*);

// ===== test/tb_camera_point_projection_distortion.sv =====
// Testbench for camera_point_projection_distortion: coefficient loads and point projections
// are streamed in, and each pixel is checked against an in-bench fixed point projection model.
// Depends on cpd_pkg and the camera_point_projection_distortion RTL.
module tb_camera_point_projection_distortion;

  typedef struct {
    cpd_pkg::action_t act;
    logic [4:0]       idx;
    logic [47:0]      val;
    logic [31:0]      px, py, pz;
  } item_t;

  typedef struct {
    logic [31:0] u, v;
    logic        bad;
  } pixel_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic [0:0]   m_tuser;

  item_t       pending_items[$];
  pixel_t      expected_pixels[$];
  item_t       cur;
  cpd_pkg::q_t coef_tab[cpd_pkg::NUM_COEFS];
  int          send_idle = 23, recv_idle = 86, fails = 0;

  camera_point_projection_distortion uut (.*);

  initial forever #5 clk = ~clk;

  function automatic logic [63:0] qmag(cpd_pkg::q_t a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic cpd_pkg::q_t qsat(logic neg, logic [127:0] p);
    if (neg) begin
      if ((|p[127:64]) || p[63]) return cpd_pkg::Q_MIN;
      return cpd_pkg::q_t'(64'd0 - p[63:0]);
    end
    if ((|p[127:64]) || p[63]) return cpd_pkg::Q_MAX;
    return cpd_pkg::q_t'(p[63:0]);
  endfunction

  function automatic cpd_pkg::q_t qadd(cpd_pkg::q_t a, cpd_pkg::q_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(cpd_pkg::Q_MAX)) return cpd_pkg::Q_MAX;
    if (s < 65'(cpd_pkg::Q_MIN)) return cpd_pkg::Q_MIN;
    return cpd_pkg::q_t'(s);
  endfunction

  function automatic cpd_pkg::q_t qsub(cpd_pkg::q_t a, cpd_pkg::q_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(cpd_pkg::Q_MAX)) return cpd_pkg::Q_MAX;
    if (s < 65'(cpd_pkg::Q_MIN)) return cpd_pkg::Q_MIN;
    return cpd_pkg::q_t'(s);
  endfunction

  function automatic cpd_pkg::q_t qmul(cpd_pkg::q_t a, cpd_pkg::q_t b);
    logic [127:0] p;
    p = {64'd0, qmag(a)} * {64'd0, qmag(b)};
    p = (p + (128'd1 << (cpd_pkg::FRAC - 1))) >> cpd_pkg::FRAC;
    return qsat(a[63] ^ b[63], p);
  endfunction

  function automatic cpd_pkg::q_t qdiv(cpd_pkg::q_t n, cpd_pkg::q_t d);
    logic [127:0] num, den, q, r;
    num = {64'd0, qmag(n)} << cpd_pkg::FRAC;
    den = {64'd0, qmag(d)};
    q = num / den;
    r = num % den;
    if ((r << 1) >= den) q = q + 1;
    return qsat(n[63] ^ d[63], q);
  endfunction

  function automatic logic [31:0] to_pix(cpd_pkg::q_t q);
    logic [63:0] m;
    m = (qmag(q) + 64'd128) >> 8;
    if (q[63]) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'd0 - m[31:0];
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic pixel_t project_point(item_t it);
    pixel_t r;
    cpd_pkg::q_t pt[3], h[3];
    cpd_pkg::q_t u, v, dx, dy, dx2, dy2, dxdy, r2, rad, x, y;
    pt[0] = cpd_pkg::q_t'($signed(it.px)) <<< 8;
    pt[1] = cpd_pkg::q_t'($signed(it.py)) <<< 8;
    pt[2] = cpd_pkg::q_t'($signed(it.pz)) <<< 8;
    for (int i = 0; i < 3; i++) begin
      h[i] = qadd(qadd(qadd(qmul(coef_tab[4*i], pt[0]), qmul(coef_tab[4*i+1], pt[1])),
                       qmul(coef_tab[4*i+2], pt[2])), coef_tab[4*i+3]);
    end
    if (h[2] == 0) begin
      r.u = h[0][63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      r.v = h[1][63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      r.bad = 1;
      return r;
    end
    u = qdiv(h[0], h[2]);
    v = qdiv(h[1], h[2]);
    dx = coef_tab[cpd_pkg::C_FX] != 0 ?
         qdiv(qsub(u, coef_tab[cpd_pkg::C_CX]), coef_tab[cpd_pkg::C_FX]) : 0;
    dy = coef_tab[cpd_pkg::C_FY] != 0 ?
         qdiv(qsub(v, coef_tab[cpd_pkg::C_CY]), coef_tab[cpd_pkg::C_FY]) : 0;
    dx2 = qmul(dx, dx);
    dy2 = qmul(dy, dy);
    dxdy = qmul(dx, dy);
    r2 = qadd(dx2, dy2);
    rad = qadd(coef_tab[cpd_pkg::C_K2], qmul(r2, coef_tab[cpd_pkg::C_K3]));
    rad = qadd(coef_tab[cpd_pkg::C_K1], qmul(r2, rad));
    rad = qadd(cpd_pkg::Q_ONE, qmul(r2, rad));
    x = qmul(dx, rad);
    x = qadd(x, qmul(qadd(coef_tab[cpd_pkg::C_P1], coef_tab[cpd_pkg::C_P1]), dxdy));
    x = qadd(x, qmul(coef_tab[cpd_pkg::C_P2], qadd(r2, qadd(dx2, dx2))));
    y = qmul(dy, rad);
    y = qadd(y, qmul(qadd(coef_tab[cpd_pkg::C_P2], coef_tab[cpd_pkg::C_P2]), dxdy));
    y = qadd(y, qmul(coef_tab[cpd_pkg::C_P1], qadd(r2, qadd(dy2, dy2))));
    r.u = to_pix(qadd(coef_tab[cpd_pkg::C_CX], qmul(coef_tab[cpd_pkg::C_FX], x)));
    r.v = to_pix(qadd(coef_tab[cpd_pkg::C_CY], qmul(coef_tab[cpd_pkg::C_FY], y)));
    r.bad = 0;
    return r;
  endfunction

  // driver: update table / predict on accept, then present next item
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      foreach (coef_tab[i]) coef_tab[i] = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (cur.act == cpd_pkg::ACT_LOAD) begin
          if (cur.idx < cpd_pkg::NUM_COEFS) coef_tab[cur.idx] = cpd_pkg::q_t'($signed(cur.val));
        end else begin
          expected_pixels.push_back(project_point(cur));
        end
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur = pending_items.pop_front();
          s_tvalid <= 1;
          s_tuser <= cur.act;
          s_tdata <= {3'b0, cur.pz, cur.py, cur.px, cur.val, cur.idx};
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel u=%h v=%h", m_tdata[31:0], m_tdata[63:32]);
          fails++;
        end else begin
          e = expected_pixels.pop_front();
          if (m_tdata[31:0] !== e.u) begin
            $error("pixel_u expected %h got %h", e.u, m_tdata[31:0]);
            fails++;
          end
          if (m_tdata[63:32] !== e.v) begin
            $error("pixel_v expected %h got %h", e.v, m_tdata[63:32]);
            fails++;
          end
          if (m_tuser[0] !== e.bad) begin
            $error("depth_bad expected %b got %b", e.bad, m_tuser[0]);
            fails++;
          end
        end
      end
      m_tready <= $urandom_range(99) >= recv_idle;
    end
  end

  task automatic add_load(logic [4:0] idx, logic [47:0] val);
    item_t it;
    it = '{cpd_pkg::ACT_LOAD, idx, val, $urandom, $urandom, $urandom};
    pending_items.push_back(it);
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    item_t it;
    it = '{cpd_pkg::ACT_PROJECT, 5'($urandom), 48'({$urandom, $urandom}), x, y, z};
    pending_items.push_back(it);
  endtask

  function automatic logic [47:0] q24(int units);
    return 48'(longint'(units) <<< 24);
  endfunction

  function automatic logic [47:0] small_coef(int span);
    return 48'(longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic load_camera();
    logic [47:0] fx, fy, cx, cy;
    fx = q24($urandom_range(100, 900));
    fy = q24($urandom_range(100, 900));
    cx = q24($urandom_range(0, 640));
    cy = q24($urandom_range(0, 480));
    for (int i = 0; i < 12; i++) add_load(5'(i), small_coef(1 << 18));
    add_load(5'd0, fx);
    add_load(5'd2, cx);
    add_load(5'd5, fy);
    add_load(5'd6, cy);
    add_load(5'd10, q24(1));
    add_load(5'd11, $urandom_range(3) == 0 ? 48'd0 : small_coef(1 << 16));
    add_load(cpd_pkg::C_CX, cx);
    add_load(cpd_pkg::C_CY, cy);
    add_load(cpd_pkg::C_FX, fx);
    add_load(cpd_pkg::C_FY, fy);
    add_load(cpd_pkg::C_K1, small_coef(1 << 23));
    add_load(cpd_pkg::C_K2, small_coef(1 << 21));
    add_load(cpd_pkg::C_K3, small_coef(1 << 19));
    add_load(cpd_pkg::C_P1, small_coef(1 << 15));
    add_load(cpd_pkg::C_P2, small_coef(1 << 15));
  endtask

  task automatic random_part(int n);
    int k;
    load_camera();
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 2) load_camera();
      else if (k < 7) add_load(5'($urandom_range(0, 20)), 48'({$urandom, $urandom}));
      else if (k < 9) add_load(5'($urandom_range(21, 31)), 48'({$urandom, $urandom}));
      else if (k < 24) add_point($urandom, $urandom, $urandom);
      else if (k < 27) add_point($urandom, $urandom, 0);
      else add_point(32'($urandom_range(0, 1 << 22)) - 32'(1 << 21),
                     32'($urandom_range(0, 1 << 22)) - 32'(1 << 21),
                     32'($urandom_range(1 << 15, 40 << 16)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    // empty table: zero depth
    add_point(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
    // identity projection, zero focal lengths
    add_load(5'd0, q24(1));
    add_load(5'd5, q24(1));
    add_load(5'd10, q24(1));
    add_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    add_load(cpd_pkg::C_CX, q24(1));
    add_load(cpd_pkg::C_CY, q24(-1));
    add_load(cpd_pkg::C_FX, q24(2));
    add_load(cpd_pkg::C_FY, q24(3));
    add_load(cpd_pkg::C_K1, small_coef(1 << 22));
    add_load(cpd_pkg::C_K2, small_coef(1 << 20));
    add_load(cpd_pkg::C_K3, small_coef(1 << 20));
    add_load(cpd_pkg::C_P1, small_coef(1 << 14));
    add_load(cpd_pkg::C_P2, small_coef(1 << 14));
    add_point(32'h0001_8000, 32'hFFFE_4000, 32'h0004_0000);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_point(32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000);
    add_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    // out of range slot must not change the table
    add_load(5'd31, 48'hFFFF_FFFF_FFFF);
    add_load(5'd21, 48'h7FFF_FFFF_FFFF);
    add_point(32'h0003_0000, 32'h0002_0000, 32'h0005_0000);
    add_load(cpd_pkg::C_K2, 48'h7FFF_FFFF_FFFF);
    add_load(cpd_pkg::C_K3, 48'h8000_0000_0000);
    add_point(32'h0003_0000, 32'h0002_0000, 32'h0001_0000);
    random_part(340);
    while (pending_items.size() > 0) @(posedge clk);
    send_idle = 86;
    recv_idle = 23;
    random_part(340);
    while (pending_items.size() > 0) @(posedge clk);
    send_idle = 0;
    recv_idle = 0;
    random_part(340);
    while (pending_items.size() > 0 || s_tvalid || expected_pixels.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
